// ===== hw/rtl/fme_pkg.sv =====
`default_nettype none
package fme_pkg;

    // Longest payload a start item may announce.
    localparam int unsigned MAX_PAYLOAD = 256;
    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes (byte address 4 * index).
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_END_FIRST   = 2'd2;
    localparam logic [1:0] REG_END_SECOND  = 2'd3;

    // Output steps of the back end. A payload command enters at the payload step and,
    // when it closes the frame, shares the trailer steps with a zero-length start.
    localparam logic [3:0] STEP_SYNC_FIRST  = 4'd0;
    localparam logic [3:0] STEP_SYNC_SECOND = 4'd1;
    localparam logic [3:0] STEP_DEST        = 4'd2;
    localparam logic [3:0] STEP_SOURCE      = 4'd3;
    localparam logic [3:0] STEP_CLASS       = 4'd4;
    localparam logic [3:0] STEP_OPCODE      = 4'd5;
    localparam logic [3:0] STEP_FLAGS       = 4'd6;
    localparam logic [3:0] STEP_SEQ         = 4'd7;
    localparam logic [3:0] STEP_LEN_LOW     = 4'd8;
    localparam logic [3:0] STEP_LEN_HIGH    = 4'd9;
    localparam logic [3:0] STEP_SUM_LOW     = 4'd10;
    localparam logic [3:0] STEP_SUM_HIGH    = 4'd11;
    localparam logic [3:0] STEP_END_FIRST   = 4'd12;
    localparam logic [3:0] STEP_END_SECOND  = 4'd13;
    localparam logic [3:0] STEP_PAYLOAD     = STEP_LEN_HIGH;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAYLOAD,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        final_byte;   // frame closes after this command
        logic [7:0]  dest_addr;
        logic [7:0]  source_addr;
        logic [7:0]  msg_class;
        logic [7:0]  msg_opcode;
        logic [7:0]  flag_bits;
        logic [7:0]  seq_number;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/framed_message_encoder_fletcher.sv =====
// Path: command queue, then back end command register, then output register.
// Throughput: one input item per cycle while the output side keeps up; the output
//   moves one byte per cycle unless out_stall holds it; a start emits 10 bytes (14
//   with no payload), a payload byte 1 (5 when it closes the frame), a reject 1.
// Reset: rst_n (async, active low) clears frame state, sums, queue and out_valid;
//   the sync and end marker registers reset to zero.
`default_nettype none
module framed_message_encoder_fletcher #(
    parameter int unsigned QUEUE_DEPTH = fme_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    // Input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  dest_addr,
    input  wire logic [7:0]  source_addr,
    input  wire logic [7:0]  msg_class,
    input  wire logic [7:0]  msg_opcode,
    input  wire logic [7:0]  flag_bits,
    input  wire logic [7:0]  seq_number,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,

    // Output bytes
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             frame_error
);

    // Marker registers. Writes land in the access phase; reads return the
    // register zero-extended to the bus width.
    fme_pkg::cfg_t cfg_reg, cfg_next;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                fme_pkg::REG_SYNC_FIRST:  cfg_next.sync_first  = pwdata[7:0];
                fme_pkg::REG_SYNC_SECOND: cfg_next.sync_second = pwdata[7:0];
                fme_pkg::REG_END_FIRST:   cfg_next.end_first   = pwdata[7:0];
                fme_pkg::REG_END_SECOND:  cfg_next.end_second  = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fme_pkg::REG_SYNC_FIRST:  prdata = {24'd0, cfg_reg.sync_first};
            fme_pkg::REG_SYNC_SECOND: prdata = {24'd0, cfg_reg.sync_second};
            fme_pkg::REG_END_FIRST:   prdata = {24'd0, cfg_reg.end_first};
            fme_pkg::REG_END_SECOND:  prdata = {24'd0, cfg_reg.end_second};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify each item against the open frame and queue a
    // command; payload bytes outside a frame are dropped here.
    fme_pkg::cmd_t push_cmd;
    fme_pkg::cmd_t head_cmd;
    logic          push;
    logic          queue_full;
    logic          pop;
    logic          head_valid;

    fme_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .dest_addr      (dest_addr),
        .source_addr    (source_addr),
        .msg_class      (msg_class),
        .msg_opcode     (msg_opcode),
        .flag_bits      (flag_bits),
        .seq_number     (seq_number),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Command queue: absorbs header and trailer bursts so the front keeps
    // taking items while the back serializes.
    fme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    // Back end: emit one byte per cycle into the output register unless the output
    // stalls, and keep the running check sums in emission order.
    fme_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_cmd    (head_cmd),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last),
        .frame_error (frame_error)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/fme_queue.sv =====
`default_nettype none
module fme_queue #(
    parameter int unsigned DEPTH = fme_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire fme_pkg::cmd_t push_cmd,
    output logic              full,
    input  wire logic         pop,
    output fme_pkg::cmd_t     head_cmd,
    output logic              head_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fme_pkg::cmd_t      entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fme_front.sv =====
`default_nettype none
module fme_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          op,
    input  wire logic [7:0]    dest_addr,
    input  wire logic [7:0]    source_addr,
    input  wire logic [7:0]    msg_class,
    input  wire logic [7:0]    msg_opcode,
    input  wire logic [7:0]    flag_bits,
    input  wire logic [7:0]    seq_number,
    input  wire logic [15:0]   payload_length,
    input  wire logic [7:0]    data_byte,
    input  wire logic          queue_full,
    output logic               push,
    output fme_pkg::cmd_t      push_cmd
);

    logic        in_frame_reg, in_frame_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        accept;
    logic        too_long;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign too_long = (payload_length > 16'(fme_pkg::MAX_PAYLOAD));

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        remaining_next = remaining_reg;
        push           = 1'b0;

        push_cmd.kind           = fme_pkg::CMD_PAYLOAD;
        push_cmd.final_byte     = 1'b0;
        push_cmd.dest_addr      = dest_addr;
        push_cmd.source_addr    = source_addr;
        push_cmd.msg_class      = msg_class;
        push_cmd.msg_opcode     = msg_opcode;
        push_cmd.flag_bits      = flag_bits;
        push_cmd.seq_number     = seq_number;
        push_cmd.payload_length = payload_length;
        push_cmd.data_byte      = data_byte;

        if (accept)
        begin
            if (op == fme_pkg::OP_START)
            begin
                push = 1'b1;
                if (too_long)
                begin
                    // Reject the start and abandon any open frame.
                    push_cmd.kind  = fme_pkg::CMD_ERROR;
                    in_frame_next  = 1'b0;
                    remaining_next = '0;
                end
                else
                begin
                    push_cmd.kind       = fme_pkg::CMD_START;
                    push_cmd.final_byte = (payload_length == '0);
                    in_frame_next       = (payload_length != '0);
                    remaining_next      = payload_length;
                end
            end
            else if (in_frame_reg && remaining_reg != '0)
            begin
                push                = 1'b1;
                push_cmd.final_byte = (remaining_reg == 16'd1);
                remaining_next      = remaining_reg - 16'd1;
                in_frame_next       = (remaining_reg != 16'd1);
            end
            else
            begin
                // Drop a payload byte that arrives outside a frame.
                in_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fme_back.sv =====
`default_nettype none
module fme_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fme_pkg::cfg_t cfg,
    input  wire fme_pkg::cmd_t head_cmd,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               frame_error
);

    fme_pkg::cmd_t cmd_reg, cmd_next;
    logic          active_reg, active_next;
    logic [3:0]    step_reg, step_next;
    logic [7:0]    sum_low_reg, sum_low_next;
    logic [7:0]    sum_high_reg, sum_high_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          last_reg, last_next;
    logic          error_reg, error_next;

    logic          can_emit;
    logic          emit_last;
    logic          is_error;
    logic          summed;
    logic [7:0]    emit_byte;
    logic [7:0]    sum_low_add;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last        = last_reg;
    assign frame_error = error_reg;

    assign is_error  = (cmd_reg.kind == fme_pkg::CMD_ERROR);
    assign can_emit  = active_reg && (!out_valid_reg || !out_stall);
    assign emit_last = is_error
                    || (step_reg == fme_pkg::STEP_LEN_HIGH && !cmd_reg.final_byte)
                    || (step_reg == fme_pkg::STEP_END_SECOND);
    assign pop       = head_valid && (!active_reg || (can_emit && emit_last));
    assign summed    = !is_error && step_reg >= fme_pkg::STEP_DEST
                    && step_reg <= fme_pkg::STEP_LEN_HIGH;
    assign sum_low_add = sum_low_reg + emit_byte;

    always_comb
    begin
        unique case (step_reg)
            fme_pkg::STEP_SYNC_FIRST:  emit_byte = is_error ? 8'h00 : cfg.sync_first;
            fme_pkg::STEP_SYNC_SECOND: emit_byte = cfg.sync_second;
            fme_pkg::STEP_DEST:        emit_byte = cmd_reg.dest_addr;
            fme_pkg::STEP_SOURCE:      emit_byte = cmd_reg.source_addr;
            fme_pkg::STEP_CLASS:       emit_byte = cmd_reg.msg_class;
            fme_pkg::STEP_OPCODE:      emit_byte = cmd_reg.msg_opcode;
            fme_pkg::STEP_FLAGS:       emit_byte = cmd_reg.flag_bits;
            fme_pkg::STEP_SEQ:         emit_byte = cmd_reg.seq_number;
            fme_pkg::STEP_LEN_LOW:     emit_byte = cmd_reg.payload_length[7:0];
            fme_pkg::STEP_LEN_HIGH:
            begin
                emit_byte = (cmd_reg.kind == fme_pkg::CMD_PAYLOAD)
                          ? cmd_reg.data_byte : cmd_reg.payload_length[15:8];
            end
            fme_pkg::STEP_SUM_LOW:     emit_byte = sum_low_reg;
            fme_pkg::STEP_SUM_HIGH:    emit_byte = sum_high_reg;
            fme_pkg::STEP_END_FIRST:   emit_byte = cfg.end_first;
            fme_pkg::STEP_END_SECOND:  emit_byte = cfg.end_second;
            default:                   emit_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        step_next      = step_reg;
        sum_low_next   = sum_low_reg;
        sum_high_next  = sum_high_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        if (can_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            last_next      = emit_last;
            error_next     = is_error;
            if (is_error
                || (cmd_reg.kind == fme_pkg::CMD_START
                    && step_reg == fme_pkg::STEP_SYNC_FIRST))
            begin
                sum_low_next  = '0;
                sum_high_next = '0;
            end
            else if (summed)
            begin
                sum_low_next  = sum_low_add;
                sum_high_next = sum_high_reg + sum_low_add;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            cmd_next    = head_cmd;
            active_next = 1'b1;
            step_next   = (head_cmd.kind == fme_pkg::CMD_PAYLOAD)
                        ? fme_pkg::STEP_PAYLOAD : fme_pkg::STEP_SYNC_FIRST;
        end
        else if (can_emit && emit_last)
        begin
            active_next = 1'b0;
        end
        else if (can_emit)
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= fme_pkg::STEP_SYNC_FIRST;
            sum_low_reg   <= '0;
            sum_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            sum_low_reg   <= sum_low_next;
            sum_high_reg  <= sum_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

endmodule
`default_nettype wire
